// ===== rtl/balanced_work_chunk_partitioner_unit_assert.svh =====
// Assertion macros used by the checker module of the partitioner.
`ifndef BALANCED_WORK_CHUNK_PARTITIONER_UNIT_ASSERT_SVH
`define BALANCED_WORK_CHUNK_PARTITIONER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BWCP_ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bwcp same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BWCP_ASSERT_NXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bwcp next-cycle check failed");

`endif

// ===== rtl/bwcp_pkg.sv =====
// Constants, control word type and microcode table of the chunk partitioner.
package bwcp_pkg;

  localparam int MAX_PATHS         = 64;
  localparam int CHUNKS_PER_WORKER = 4;

  localparam int PTS_W      = 20;
  localparam int SUM_W      = 26;
  localparam int PATH_CNT_W = $clog2(MAX_PATHS + 1);
  localparam int PATH_IDX_W = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
  localparam int WL_W       = 7;
  localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
  localparam int UPC_W      = 4;
  localparam int JC_W       = 3;

  localparam logic [WL_W-1:0]      WL_RESET  = WL_W'(1);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(SUM_W);

  localparam logic [UPC_W-1:0] S_SETUP = 4'd0;
  localparam logic [UPC_W-1:0] S_CHUNK = 4'd1;
  localparam logic [UPC_W-1:0] S_DIV   = 4'd2;
  localparam logic [UPC_W-1:0] S_FIX   = 4'd3;
  localparam logic [UPC_W-1:0] S_READ  = 4'd4;
  localparam logic [UPC_W-1:0] S_ACC   = 4'd5;
  localparam logic [UPC_W-1:0] S_CHECK = 4'd6;
  localparam logic [UPC_W-1:0] S_EMIT  = 4'd7;
  localparam logic [UPC_W-1:0] S_DONE  = 4'd8;

  localparam logic [JC_W-1:0] J_NEXT     = 3'd0;
  localparam logic [JC_W-1:0] J_FINAL    = 3'd1;
  localparam logic [JC_W-1:0] J_DIV_LOOP = 3'd2;
  localparam logic [JC_W-1:0] J_MORE     = 3'd3;
  localparam logic [JC_W-1:0] J_NOT_LAST = 3'd4;
  localparam logic [JC_W-1:0] J_HALT     = 3'd5;

  typedef struct packed {
    logic [JC_W-1:0]  jcond;
    logic [UPC_W-1:0] jaddr;
    logic             setup;
    logic             chunk;
    logic             div_step;
    logic             fix;
    logic             rd;
    logic             acc;
    logic             emit;
    logic             clr;
  } ucw_t;

  function automatic ucw_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucw_t w;
    w = '0;
    w.jcond = J_NEXT;
    w.jaddr = S_SETUP;
    unique case (addr)
      S_SETUP: begin
        w.setup = 1'b1;
      end
      S_CHUNK: begin
        w.chunk = 1'b1;
        w.jcond = J_FINAL;
        w.jaddr = S_READ;
      end
      S_DIV: begin
        w.div_step = 1'b1;
        w.jcond    = J_DIV_LOOP;
        w.jaddr    = S_DIV;
      end
      S_FIX: begin
        w.fix = 1'b1;
      end
      S_READ: begin
        w.rd = 1'b1;
      end
      S_ACC: begin
        w.acc = 1'b1;
      end
      S_CHECK: begin
        w.jcond = J_MORE;
        w.jaddr = S_READ;
      end
      S_EMIT: begin
        w.emit  = 1'b1;
        w.jcond = J_NOT_LAST;
        w.jaddr = S_CHUNK;
      end
      S_DONE: begin
        w.clr   = 1'b1;
        w.jcond = J_HALT;
      end
      default: begin
        w.jcond = J_HALT;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/balanced_work_chunk_partitioner_unit.sv =====
// Top level of the balanced work chunk partitioner with its microcoded sequencer.
//
//   channel  handshake            payload
//   in       start, busy          in_point_count, in_last_path
//   out      out_valid (strobe)   out_chunk_begin, out_chunk_end, out_chunk_total,
//                                 out_last_chunk, out_too_many_paths
//   cfg      cfg_valid, cfg_ready cfg_worker_limit
//
// A path item without the last flag is stored and busy stays low. The last item
// starts the sequencer: a setup step, then per chunk a chunk step, a 26-step restoring
// division and a fix step (the final chunk skips the division and the fix), a read,
// accumulate and check step per path read from the size memory, an emit step, and a step
// to close the group. Synchronous reset clears the group and sets the worker limit to 1.
// Results appear for one cycle each; the receiver cannot stall them.
module balanced_work_chunk_partitioner_unit import bwcp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [PTS_W-1:0]      in_point_count,
  input  logic                  in_last_path,
  output logic                  out_valid,
  output logic [PATH_IDX_W-1:0] out_chunk_begin,
  output logic [PATH_CNT_W-1:0] out_chunk_end,
  output logic [SUM_W-1:0]      out_chunk_total,
  output logic                  out_last_chunk,
  output logic                  out_too_many_paths,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [WL_W-1:0]       cfg_worker_limit
);

  logic                  run_r, run_nxt;
  logic [UPC_W-1:0]      upc_r, upc_nxt;
  ucw_t                  uw;
  logic                  take;

  logic [WL_W-1:0]       wl_r;
  logic [PATH_CNT_W-1:0] paths_r;
  logic [SUM_W-1:0]      total_r;
  logic                  ovf_r;

  logic [PTS_W-1:0]      mem [MAX_PATHS];
  logic [PTS_W-1:0]      rdata_r;

  logic [PATH_CNT_W-1:0] rc_r, begin_r, end_r, latest_r;
  logic [SUM_W-1:0]      sum_r, target_r, remain_r, quo_r;
  logic [PATH_CNT_W-1:0] rem_r;
  logic [DIV_CNT_W-1:0]  dcnt_r;

  logic                  out_valid_r;
  logic [PATH_IDX_W-1:0] out_begin_r;
  logic [PATH_CNT_W-1:0] out_end_r;
  logic [SUM_W-1:0]      out_sum_r;
  logic                  out_last_r;
  logic                  out_ovf_r;

  logic                  acc_in;
  logic                  has_room;
  logic [WL_W-1:0]       limit;
  logic [PATH_CNT_W-1:0] per_set;
  logic [PATH_CNT_W-1:0] chunk_cnt;
  logic [PATH_CNT_W:0]   trial;
  logic                  q_bit;
  logic [PATH_CNT_W-1:0] rem_next;
  logic                  more;
  logic                  end_last;
  logic                  final_chunk;

  assign busy      = run_r;
  assign cfg_ready = ~run_r;
  assign acc_in    = start & ~run_r;
  assign has_room  = (paths_r < PATH_CNT_W'(MAX_PATHS));
  assign uw        = ucode_rom(upc_r);

  assign limit     = (wl_r == '0) ? WL_W'(1) : wl_r;
  assign per_set   = PATH_CNT_W'((paths_r + (CHUNKS_PER_WORKER - 1)) / CHUNKS_PER_WORKER);
  assign chunk_cnt = (WL_W'(per_set) <= limit) ? paths_r
                                               : PATH_CNT_W'(limit * CHUNKS_PER_WORKER);

  assign trial    = {rem_r, quo_r[SUM_W-1]};
  assign q_bit    = (trial >= {1'b0, rc_r});
  assign rem_next = q_bit ? PATH_CNT_W'(trial - {1'b0, rc_r}) : trial[PATH_CNT_W-1:0];

  assign final_chunk = (rc_r <= PATH_CNT_W'(1));
  assign more        = (end_r < latest_r) && (sum_r < target_r);
  assign end_last    = (end_r >= paths_r);

  always_comb begin
    take = 1'b0;
    unique case (uw.jcond)
      J_NEXT:     take = 1'b0;
      J_FINAL:    take = final_chunk;
      J_DIV_LOOP: take = (dcnt_r != DIV_CNT_W'(1));
      J_MORE:     take = more;
      J_NOT_LAST: take = ~end_last;
      J_HALT:     take = 1'b0;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    if (!run_r) begin
      run_nxt = acc_in & in_last_path;
      upc_nxt = S_SETUP;
    end else begin
      run_nxt = (uw.jcond != J_HALT);
      upc_nxt = take ? uw.jaddr : upc_r + UPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      upc_r       <= S_SETUP;
      wl_r        <= WL_RESET;
      paths_r     <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      run_r       <= run_nxt;
      upc_r       <= upc_nxt;
      out_valid_r <= run_r & uw.emit;
      if (cfg_valid & cfg_ready) begin
        wl_r <= cfg_worker_limit;
      end
      if (acc_in) begin
        if (has_room) begin
          paths_r <= paths_r + PATH_CNT_W'(1);
          total_r <= total_r + SUM_W'(in_point_count);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (run_r & uw.clr) begin
        paths_r <= '0;
        total_r <= '0;
        ovf_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in & has_room) begin
      mem[paths_r[PATH_IDX_W-1:0]] <= in_point_count;
    end
    if (run_r & uw.rd) begin
      rdata_r <= mem[end_r[PATH_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (run_r) begin
      if (uw.setup) begin
        rc_r     <= chunk_cnt;
        remain_r <= total_r;
        begin_r  <= '0;
      end
      if (uw.chunk) begin
        sum_r  <= '0;
        end_r  <= begin_r;
        quo_r  <= remain_r;
        rem_r  <= '0;
        dcnt_r <= DIV_STEPS;
        if (final_chunk) begin
          latest_r <= paths_r;
          target_r <= '1;
        end else begin
          latest_r <= paths_r - (rc_r - PATH_CNT_W'(1));
        end
      end
      if (uw.div_step) begin
        quo_r  <= {quo_r[SUM_W-2:0], q_bit};
        rem_r  <= rem_next;
        dcnt_r <= dcnt_r - DIV_CNT_W'(1);
      end
      if (uw.fix) begin
        target_r <= quo_r + SUM_W'(rem_r != '0);
      end
      if (uw.acc) begin
        sum_r <= sum_r + SUM_W'(rdata_r);
        end_r <= end_r + PATH_CNT_W'(1);
      end
      if (uw.emit) begin
        remain_r    <= remain_r - sum_r;
        begin_r     <= end_r;
        rc_r        <= rc_r - PATH_CNT_W'(1);
        out_begin_r <= begin_r[PATH_IDX_W-1:0];
        out_end_r   <= end_r;
        out_sum_r   <= sum_r;
        out_last_r  <= end_last;
        out_ovf_r   <= ovf_r;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_chunk_begin    = out_begin_r;
  assign out_chunk_end      = out_end_r;
  assign out_chunk_total    = out_sum_r;
  assign out_last_chunk     = out_last_r;
  assign out_too_many_paths = out_ovf_r;

endmodule

// ===== rtl/bwcp_checker.sv =====
// Port-level checker for the chunk partitioner and its bind to the top level.
`include "balanced_work_chunk_partitioner_unit_assert.svh"

module bwcp_checker import bwcp_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  in_last_path,
  input logic                  out_valid,
  input logic [PATH_IDX_W-1:0] out_chunk_begin,
  input logic [PATH_CNT_W-1:0] out_chunk_end,
  input logic                  out_last_chunk
);

  `BWCP_ASSERT_IMP(a_out_only_busy, clk, rst_n, out_valid, busy)
  `BWCP_ASSERT_NXT(a_last_starts, clk, rst_n, start && !busy && in_last_path, busy)
  `BWCP_ASSERT_NXT(a_out_spaced, clk, rst_n, out_valid, !out_valid)
  `BWCP_ASSERT_IMP(a_chunk_nonempty, clk, rst_n, out_valid, out_chunk_end > PATH_CNT_W'(out_chunk_begin))
  `BWCP_ASSERT_NXT(a_more_follows, clk, rst_n, out_valid && !out_last_chunk, busy)

endmodule

bind balanced_work_chunk_partitioner_unit bwcp_checker u_bwcp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_last_path   (in_last_path),
  .out_valid      (out_valid),
  .out_chunk_begin(out_chunk_begin),
  .out_chunk_end  (out_chunk_end),
  .out_last_chunk (out_last_chunk)
);
